[design/scba_pkg.sv]
package scba_pkg;

	// register file of block sizes
	localparam int NUM_REGS = 7;
	localparam int CFG_IDX_W = 3;
	localparam int BYTES_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CLASS0_BYTES = 3'd0;
	localparam cfg_idx_t REG_CLASS1_BYTES = 3'd1;
	localparam cfg_idx_t REG_CLASS2_BYTES = 3'd2;
	localparam cfg_idx_t REG_CLASS3_BYTES = 3'd3;
	localparam cfg_idx_t REG_CLASS4_BYTES = 3'd4;
	localparam cfg_idx_t REG_CLASS5_BYTES = 3'd5;
	localparam cfg_idx_t REG_CLASS6_BYTES = 3'd6;

	localparam logic [BYTES_W-1:0] RESET_BYTES [NUM_REGS] = '{
		16'd32, 16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd2048
	};

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_ZERO = 3'd1;
	localparam status_t ST_TOO_LARGE = 3'd2;
	localparam status_t ST_EXHAUSTED = 3'd3;
	localparam status_t ST_OVERFLOW = 3'd4;

	typedef struct packed {
		logic operation;
		logic [BYTES_W-1:0] request_bytes;
		logic [2:0] free_class;
		logic [7:0] free_block;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [2:0] block_class;
		logic [7:0] block_index;
	} rsp_t;

	// size class lookup result
	typedef struct packed {
		logic hit;
		logic [2:0] cls;
	} sel_t;

endpackage

[design/scba_class_select.sv]
module scba_class_select #(
	parameter int LIVE_CLASSES = 7
) (
	input logic [scba_pkg::BYTES_W-1:0] request_bytes,
	input logic [scba_pkg::BYTES_W-1:0] class_bytes [scba_pkg::NUM_REGS],
	output scba_pkg::sel_t sel
);

	// first covering class wins, so scan from the top down
	always_comb begin
		sel = '0;
		for (int c = LIVE_CLASSES - 1; c >= 0; c--) begin
			if (request_bytes <= class_bytes[c]) begin
				sel.hit = 1'b1;
				sel.cls = 3'(c);
			end
		end
	end

endmodule

[design/scba_stack_ram.sv]
module scba_stack_ram #(
	parameter int DEPTH = 1792,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 8
) (
	input logic clk,
	input logic we,
	input logic re,
	input logic [ADDR_W-1:0] addr,
	input logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/size_class_block_allocator.sv]
// Fixed-block allocator with up to seven live size classes, each a LIFO stack
// of free block indexes held in one shared synchronous RAM.
// req channel: an allocate (byte count) or a free (class, block) transaction,
// taken when req_valid is high and req_stall is low.
// rsp channel: exactly one response per request, in order, with status,
// class and block index; held stable while rsp_stall is high.
// A response is valid in the cycle after its request. A request is accepted in
// every cycle while the response register is free or draining, so the block
// sustains one transaction per clock; the single RAM port does one pop read
// or one push write per transaction and the per-class counts update at accept.
// Stalling the response with a full response register stalls the request
// side in the same cycle.
// Reset empties the response register and marks every block free, highest
// index on top: a per-class low-water count tells which
// stack slots were ever written, and unwritten slots read as their own index.
// The cfg port writes block size registers; it should only be written while
// no transaction is in flight.
module size_class_block_allocator #(
	parameter int SIZE_CLASSES = 7,
	parameter int BLOCKS_PER_CLASS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input scba_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output scba_pkg::rsp_t rsp,
	input logic cfg_we,
	input scba_pkg::cfg_idx_t cfg_index,
	input logic [scba_pkg::BYTES_W-1:0] cfg_data
);

	localparam int LIVE_CLASSES =
		(SIZE_CLASSES < scba_pkg::NUM_REGS) ? SIZE_CLASSES : scba_pkg::NUM_REGS;
	localparam int IDX_W = $clog2(BLOCKS_PER_CLASS);
	localparam int CNT_W = $clog2(BLOCKS_PER_CLASS + 1);
	localparam int CLS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int ADDR_W = CLS_W + IDX_W;
	localparam int DEPTH = SIZE_CLASSES * (2 ** IDX_W);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BLOCKS_PER_CLASS);

	logic [scba_pkg::BYTES_W-1:0] class_bytes_q [scba_pkg::NUM_REGS];
	logic [CNT_W-1:0] free_cnt_q [SIZE_CLASSES];
	logic [CNT_W-1:0] low_mark_q [SIZE_CLASSES];

	scba_pkg::sel_t sel;
	logic accept;
	logic [2:0] op_cls;
	logic [CNT_W-1:0] cnt_sel;
	logic [CNT_W-1:0] mark_sel;
	logic do_pop;
	logic do_push;
	logic [IDX_W-1:0] pos;
	logic [ADDR_W-1:0] ram_addr;
	logic [IDX_W-1:0] ram_rdata;
	scba_pkg::status_t status_d;

	logic rsp_valid_s1;
	scba_pkg::status_t status_s1;
	logic [2:0] cls_s1;
	logic from_ram_s1;
	logic [IDX_W-1:0] index_s1;

	// block size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < scba_pkg::NUM_REGS; r++) begin
				class_bytes_q[r] <= scba_pkg::RESET_BYTES[r];
			end
		end else if (cfg_we && (32'(cfg_index) < scba_pkg::NUM_REGS)) begin
			class_bytes_q[cfg_index] <= cfg_data;
		end
	end

	scba_class_select #(
		.LIVE_CLASSES(LIVE_CLASSES)
	) u_select (
		.request_bytes(req.request_bytes),
		.class_bytes(class_bytes_q),
		.sel(sel)
	);

	assign req_stall = rsp_valid_s1 && rsp_stall;
	assign accept = req_valid && !req_stall;

	// count and low-water mark of the addressed class
	always_comb begin
		op_cls = (req.operation == scba_pkg::OP_ALLOC) ? sel.cls : req.free_class;
		cnt_sel = '0;
		mark_sel = '0;
		for (int c = 0; c < SIZE_CLASSES; c++) begin
			if (32'(op_cls) == c) begin
				cnt_sel = free_cnt_q[c];
				mark_sel = low_mark_q[c];
			end
		end
	end

	// decode the transaction
	always_comb begin
		do_pop = 1'b0;
		do_push = 1'b0;
		pos = '0;
		if (req.operation == scba_pkg::OP_ALLOC) begin
			if (req.request_bytes == '0) begin
				status_d = scba_pkg::ST_ZERO;
			end else if (!sel.hit) begin
				status_d = scba_pkg::ST_TOO_LARGE;
			end else if (cnt_sel == '0) begin
				status_d = scba_pkg::ST_EXHAUSTED;
			end else begin
				status_d = scba_pkg::ST_OK;
				do_pop = 1'b1;
				pos = IDX_W'(cnt_sel - 1'b1);
			end
		end else begin
			if ((32'(req.free_class) >= LIVE_CLASSES) ||
				(32'(req.free_block) >= BLOCKS_PER_CLASS) ||
				(cnt_sel >= FULL_CNT)) begin
				status_d = scba_pkg::ST_OVERFLOW;
			end else begin
				status_d = scba_pkg::ST_OK;
				do_push = 1'b1;
				pos = IDX_W'(cnt_sel);
			end
		end
	end

	assign ram_addr = {op_cls[CLS_W-1:0], pos};

	scba_stack_ram #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(IDX_W)
	) u_stack (
		.clk(clk),
		.we(accept && do_push),
		.re(accept && do_pop),
		.addr(ram_addr),
		.wdata(IDX_W'(req.free_block)),
		.rdata(ram_rdata)
	);

	// per-class counts, updated at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < SIZE_CLASSES; c++) begin
				free_cnt_q[c] <= FULL_CNT;
				low_mark_q[c] <= FULL_CNT;
			end
		end else if (accept) begin
			for (int c = 0; c < SIZE_CLASSES; c++) begin
				if (32'(op_cls) == c) begin
					if (do_pop) begin
						free_cnt_q[c] <= free_cnt_q[c] - 1'b1;
						if ((free_cnt_q[c] - 1'b1) < low_mark_q[c]) begin
							low_mark_q[c] <= free_cnt_q[c] - 1'b1;
						end
					end else if (do_push) begin
						free_cnt_q[c] <= free_cnt_q[c] + 1'b1;
					end
				end
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (accept) begin
			rsp_valid_s1 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s1 <= 1'b0;
		end
	end

	// response payload; slots below the low-water mark were never written
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			cls_s1 <= do_pop ? sel.cls : 3'd0;
			from_ram_s1 <= do_pop && (CNT_W'(pos) >= mark_sel);
			index_s1 <= do_pop ? pos : '0;
		end
	end

	assign rsp_valid = rsp_valid_s1;
	assign rsp.status = status_s1;
	assign rsp.block_class = cls_s1;
	assign rsp.block_index = from_ram_s1 ? 8'(ram_rdata) : 8'(index_s1);

`ifndef SYNTHESIS
	// the request side only waits on a held response
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no response pending");

	// a successful pop answers ok with the chosen class next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_pop) |=> (rsp_valid && (rsp.status == scba_pkg::ST_OK) &&
			(rsp.block_class == $past(sel.cls))))
		else $error("pop response lost or wrong class");

	// failed transactions carry no handle
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != scba_pkg::ST_OK)) |->
			((rsp.block_class == 3'd0) && (rsp.block_index == 8'd0)))
		else $error("failed response carries a handle");

	// low-water mark never rises above the count, nor the count above a full class
	for (genvar g = 0; g < SIZE_CLASSES; g++) begin : g_mark_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			(low_mark_q[g] <= free_cnt_q[g]) && (free_cnt_q[g] <= FULL_CNT))
			else $error("free count out of range for a class");
	end
`endif

endmodule

[dv/size_class_block_allocator_tb.sv]
module size_class_block_allocator_tb;
	import scba_pkg::*;

	localparam int CLASSES = 7;
	localparam int BLOCKS = 256;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTS = 100;

	localparam cfg_idx_t SIZE_REGS [CLASSES] = '{
		REG_CLASS0_BYTES, REG_CLASS1_BYTES, REG_CLASS2_BYTES, REG_CLASS3_BYTES,
		REG_CLASS4_BYTES, REG_CLASS5_BYTES, REG_CLASS6_BYTES
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_CLASS0_BYTES;
	logic [BYTES_W-1:0] cfg_data = '0;

	size_class_block_allocator #(
		.SIZE_CLASSES(CLASSES),
		.BLOCKS_PER_CLASS(BLOCKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// stimulus side state
	req_t request_queue [$];
	int gen_bytes [CLASSES];
	bit gaps_on = 1'b1;
	int hold_asked = 0;
	int settings_used = 0;

	// allocator shadow state
	logic [BYTES_W-1:0] class_bytes_q [CLASSES];
	logic [7:0] free_lifo [CLASSES][BLOCKS];
	int free_cnt [CLASSES];
	rsp_t expected_rsp [$];

	// handshake bookkeeping
	bit req_fire = 1'b0;
	bit rsp_fire = 1'b0;
	int n_req_acc = 0;
	int n_rsp_acc = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int tally [5];
	rsp_t want;

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch @%0t: %s", $time, msg);
	endtask

	function automatic int draw_gap();
		return gaps_on ? int'($urandom_range(0, 5)) : 0;
	endfunction

	// restore shadow state to the reset picture: every block free, highest on top
	function automatic void shadow_reset();
		int c, i;
		for (c = 0; c < CLASSES; c++) begin
			class_bytes_q[c] = RESET_BYTES[c];
			free_cnt[c] = BLOCKS;
			for (i = 0; i < BLOCKS; i++)
				free_lifo[c][i] = 8'(i);
		end
	endfunction

	// expected response of one request, updating the shadow stacks
	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int c;
		int hit;
		o = '0;
		hit = -1;
		if (r.operation == OP_ALLOC) begin
			if (r.request_bytes == '0) begin
				o.status = ST_ZERO;
			end else begin
				for (c = 0; c < CLASSES; c++)
					if (hit < 0 && r.request_bytes <= class_bytes_q[c])
						hit = c;
				if (hit < 0) begin
					o.status = ST_TOO_LARGE;
				end else if (free_cnt[hit] == 0) begin
					o.status = ST_EXHAUSTED;
				end else begin
					free_cnt[hit]--;
					o.status = ST_OK;
					o.block_class = 3'(hit);
					o.block_index = free_lifo[hit][free_cnt[hit]];
				end
			end
		end else begin
			if (r.free_class >= CLASSES || free_cnt[r.free_class] >= BLOCKS) begin
				o.status = ST_OVERFLOW;
			end else begin
				free_lifo[r.free_class][free_cnt[r.free_class]] = r.free_block;
				free_cnt[r.free_class]++;
				o.status = ST_OK;
			end
		end
		return o;
	endfunction

	// request driver
	int drv_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(req_valid && !req_fire)) begin
				if (req_fire)
					drv_gap = draw_gap();
				if (drv_gap > 0) begin
					drv_gap--;
					req_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					req_item <= request_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response receiver with random backpressure and an occasional long hold
	int rcv_gap = 0;
	int hold_served = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (rsp_fire)
				rcv_gap = draw_gap();
			else if (rcv_gap > 0 && rsp_valid)
				rcv_gap--;
			if (hold_left > 0)
				hold_left--;
			rsp_stall <= (hold_left > 0) || (rcv_gap > 0);
		end
	end

	// monitor: predict on request transaction, check on response transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			shadow_reset();
			req_fire <= 1'b0;
			rsp_fire <= 1'b0;
		end else begin
			if (cfg_we && cfg_index < CLASSES)
				class_bytes_q[cfg_index] = cfg_data;
			req_fire <= req_valid && !req_stall;
			rsp_fire <= rsp_valid && !rsp_stall;
			if (req_valid && !req_stall) begin
				want = serve_request(req_item);
				tally[want.status]++;
				expected_rsp.push_back(want);
				n_req_acc <= n_req_acc + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsp_acc <= n_rsp_acc + 1;
				if (expected_rsp.size() == 0) begin
					report_mismatch("response with nothing outstanding");
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_item.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_item.status, want.status));
					if (rsp_item.block_class !== want.block_class)
						report_mismatch($sformatf("block_class %0d, want %0d",
							rsp_item.block_class, want.block_class));
					if (rsp_item.block_index !== want.block_index)
						report_mismatch($sformatf("block_index %0d, want %0d",
							rsp_item.block_index, want.block_index));
				end
			end
			// watchdog on lack of progress
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// stimulus helpers
	task automatic add_alloc(logic [15:0] bytes);
		req_t r;
		r.operation = OP_ALLOC;
		r.request_bytes = bytes;
		r.free_class = 3'($urandom_range(0, 7));
		r.free_block = 8'($urandom_range(0, 255));
		request_queue.push_back(r);
	endtask

	task automatic add_free(logic [2:0] cls, logic [7:0] blk);
		req_t r;
		r.operation = OP_FREE;
		r.request_bytes = 16'($urandom_range(0, 65535));
		r.free_class = cls;
		r.free_block = blk;
		request_queue.push_back(r);
	endtask

	// byte count that lands in class k under an ascending setting
	function automatic logic [15:0] pick_bytes(int k);
		int lo, hi, i;
		lo = 1;
		hi = gen_bytes[k];
		for (i = 0; i < k; i++)
			if (gen_bytes[i] + 1 > lo)
				lo = gen_bytes[i] + 1;
		if (hi < lo)
			return 16'($urandom_range(1, 65535));
		if ($urandom_range(0, 3) == 0)
			return 16'(hi);
		if ($urandom_range(0, 3) == 0)
			return 16'(lo);
		return 16'($urandom_range(lo, hi));
	endfunction

	function automatic logic [15:0] above_largest();
		int top, i;
		top = 0;
		for (i = 0; i < CLASSES; i++)
			if (gen_bytes[i] > top)
				top = gen_bytes[i];
		if (top >= 65535)
			return 16'hFFFF;
		return 16'($urandom_range(top + 1, 65535));
	endfunction

	task automatic wait_drained();
		do
			@(posedge clk);
		while (request_queue.size() != 0 || req_valid || n_req_acc != n_rsp_acc);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_sizes(input int vals [CLASSES]);
		int i;
		for (i = 0; i < CLASSES; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= SIZE_REGS[i];
			cfg_data <= vals[i][15:0];
			gen_bytes[i] = vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// alloc/free bursts on one class with some malformed noise mixed in
	task automatic mixed_traffic(int n);
		int made, k, len, nf, j, pick;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				k = $urandom_range(0, CLASSES - 1);
				len = $urandom_range(1, 16);
				nf = $urandom_range(0, len + 2);
				for (j = 0; j < len; j++)
					add_alloc(pick_bytes(k));
				for (j = 0; j < nf; j++)
					add_free(3'(k), 8'($urandom_range(0, 255)));
				made += len + nf;
			end else begin
				case ($urandom_range(0, 4))
					0: add_alloc(16'h0000);
					1: add_alloc(16'($urandom_range(0, 65535)));
					2: add_alloc(above_largest());
					3: add_free(3'd7, 8'($urandom_range(0, 255)));
					default: add_free(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				endcase
				made++;
			end
		end
	endtask

	// main sequence
	initial begin
		int vals [CLASSES];
		int sorted_q [$];
		int i;
		for (i = 0; i < CLASSES; i++)
			gen_bytes[i] = RESET_BYTES[i];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: boundaries, zero, too large, overflow, double free
		add_alloc(16'h0000);
		add_alloc(16'd1);
		add_alloc(16'd32);
		add_alloc(16'd33);
		add_alloc(16'd2048);
		add_alloc(16'd2049);
		add_alloc(16'hFFFF);
		add_free(3'd0, 8'hFF);
		add_free(3'd0, 8'h00);
		add_free(3'd0, 8'hAA);
		add_free(3'd7, 8'h55);
		add_free(3'd6, 8'h00);
		add_alloc(16'd2000);
		add_alloc(16'd129);
		add_alloc(16'd256);
		add_free(3'd3, 8'h12);
		add_free(3'd3, 8'h12);
		add_alloc(16'd200);
		add_alloc(16'd255);
		add_alloc(16'h5555);
		add_alloc(16'hAAAA);
		add_free(3'd1, 8'hFF);
		wait_drained();

		// drain one class past empty and refill past full, receiver held off
		hold_asked++;
		for (i = 0; i < BLOCKS + 2; i++)
			add_alloc(pick_bytes(2));
		for (i = 0; i < BLOCKS + 2; i++)
			add_free(3'd2, 8'($urandom_range(0, 255)));
		wait_drained();

		// every class at the largest size
		for (i = 0; i < CLASSES; i++)
			vals[i] = 65535;
		write_sizes(vals);
		mixed_traffic(150);
		wait_drained();

		// every class at the smallest size
		for (i = 0; i < CLASSES; i++)
			vals[i] = 1;
		write_sizes(vals);
		mixed_traffic(120);
		wait_drained();

		// zero sizes never cover, duplicated sizes shadow the later class
		vals = '{0, 16, 0, 300, 300, 0, 65535};
		write_sizes(vals);
		mixed_traffic(150);
		wait_drained();

		// random ascending sizes, no idling on either side
		sorted_q = {};
		for (i = 0; i < CLASSES; i++)
			sorted_q.push_back($urandom_range(1, 65535));
		sorted_q.sort();
		for (i = 0; i < CLASSES; i++)
			vals[i] = sorted_q[i];
		gaps_on = 1'b0;
		write_sizes(vals);
		mixed_traffic(200);
		wait_drained();
		gaps_on = 1'b1;

		// random unordered sizes
		for (i = 0; i < CLASSES; i++)
			vals[i] = $urandom_range(0, 65535);
		write_sizes(vals);
		mixed_traffic(150);
		wait_drained();

		// back to the reset sizes
		for (i = 0; i < CLASSES; i++)
			vals[i] = RESET_BYTES[i];
		write_sizes(vals);
		mixed_traffic(150);
		wait_drained();

		repeat (10) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
		$display("covered %0d requests across %0d size settings plus reset sizes",
			n_req_acc, settings_used);
		$display("ok %0d, zero size %0d, too large %0d, exhausted %0d, overflow %0d",
			tally[ST_OK], tally[ST_ZERO], tally[ST_TOO_LARGE], tally[ST_EXHAUSTED],
			tally[ST_OVERFLOW]);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
